// ----- rtl/cpc_pkg.sv -----
// Shared types, constants and the arctangent table of the coordinate converter.
package cpc_pkg;

	// Default guard bits and CORDIC stage count.
	localparam int DATA_WIDTH_DEF = 16;
	localparam int ITERATIONS_DEF = 16;

	// Fixed widths of the coordinate fields.
	localparam int COORD_W  = 16;
	localparam int RADIUS_W = 15;

	// Angle accumulator: 32 bits with pi equal to 2^31, plus a sign bit for rotation.
	localparam int Z_W = 33;
	localparam logic signed [Z_W-1:0] PI_Z = 33'sh080000000;

	// CORDIC gain compensation, K * 2^32.
	localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

	typedef enum logic {
		OP_TO_POLAR = 1'b0,
		OP_TO_CART  = 1'b1
	} op_t;

	// Control that travels with every pipeline stage.
	typedef struct packed {
		logic vld;
		op_t  op;
		logic origin;
	} ctl_t;

	// One result transaction, radius in the lowest bits.
	typedef struct packed {
		logic        [15:0] y_out;
		logic        [15:0] x_out;
		logic        [15:0] angle_out;
		logic        [15:0] radius_out;
	} res_t;

	// atan(2^-i) with pi equal to 2^31.
	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/cpc_pre.sv -----
// Input stage: scales the operands and folds them into the CORDIC convergence range.
module cpc_pre #(
	parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   vld,
	input  cpc_pkg::op_t                           opcode,
	input  logic signed [cpc_pkg::COORD_W-1:0]     x_in,
	input  logic signed [cpc_pkg::COORD_W-1:0]     y_in,
	input  logic        [cpc_pkg::RADIUS_W-1:0]    radius_in,
	input  logic signed [cpc_pkg::COORD_W-1:0]     angle_in,
	output cpc_pkg::ctl_t                          ctl,
	output logic signed [cpc_pkg::COORD_W+DATA_WIDTH+2:0] x,
	output logic signed [cpc_pkg::COORD_W+DATA_WIDTH+2:0] y,
	output logic signed [cpc_pkg::Z_W-1:0]         z
);
	import cpc_pkg::*;

	localparam int XW = COORD_W + DATA_WIDTH + 3;

	logic signed [XW-1:0]  xe, ye, re;
	logic signed [Z_W-1:0] za;
	logic                  reduce;
	ctl_t                  ctl_d;
	logic signed [XW-1:0]  x_d, y_d;
	logic signed [Z_W-1:0] z_d;

	always_comb begin
		xe     = XW'(x_in) <<< DATA_WIDTH;
		ye     = XW'(y_in) <<< DATA_WIDTH;
		re     = $signed({{(XW-RADIUS_W){1'b0}}, radius_in}) <<< DATA_WIDTH;
		za     = $signed({angle_in[COORD_W-1], angle_in, 16'h0000});
		reduce = (angle_in >= 16'sd16384) || (angle_in < -16'sd16384);

		ctl_d.vld    = vld;
		ctl_d.op     = opcode;
		ctl_d.origin = (opcode == OP_TO_POLAR) && (x_in == '0) && (y_in == '0);

		if (opcode == OP_TO_POLAR) begin
			// A vector in the left half plane is turned by pi first.
			if (x_in < 0) begin
				x_d = -xe;
				y_d = -ye;
				z_d = PI_Z;
			end else begin
				x_d = xe;
				y_d = ye;
				z_d = '0;
			end
		end else begin
			// Targets beyond a quarter turn: negate the radius, move the angle by pi.
			y_d = '0;
			if (reduce) begin
				x_d = -re;
				z_d = (za >= 0) ? za - PI_Z : za + PI_Z;
			end else begin
				x_d = re;
				z_d = za;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl <= '0;
		end else if (en) begin
			ctl <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x <= x_d;
			y <= y_d;
			z <= z_d;
		end
	end

endmodule

// ----- rtl/cpc_iter.sv -----
// One registered CORDIC micro-rotation with a fixed shift.
module cpc_iter #(
	parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEF,
	parameter int SHIFT      = 0
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  cpc_pkg::ctl_t                                 ctl_in,
	input  logic signed [cpc_pkg::COORD_W+DATA_WIDTH+2:0] x_in,
	input  logic signed [cpc_pkg::COORD_W+DATA_WIDTH+2:0] y_in,
	input  logic signed [cpc_pkg::Z_W-1:0]                z_in,
	output cpc_pkg::ctl_t                                 ctl_out,
	output logic signed [cpc_pkg::COORD_W+DATA_WIDTH+2:0] x_out,
	output logic signed [cpc_pkg::COORD_W+DATA_WIDTH+2:0] y_out,
	output logic signed [cpc_pkg::Z_W-1:0]                z_out
);
	import cpc_pkg::*;

	localparam int XW = COORD_W + DATA_WIDTH + 3;
	localparam logic signed [Z_W-1:0] ATAN = $signed({1'b0, atan_entry(5'(SHIFT))});

	logic signed [XW-1:0] xs, ys;
	logic                 turn_neg;

	// Shifts are arithmetic, so they round toward minus infinity.
	assign xs = x_in >>> SHIFT;
	assign ys = y_in >>> SHIFT;

	// Vectoring drives y to zero, rotation drives z to zero.
	assign turn_neg = (ctl_in.op == OP_TO_POLAR) ? (y_in < 0) : (z_in >= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (turn_neg) begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - ATAN;
			end else begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + ATAN;
			end
		end
	end

endmodule

// ----- rtl/cpc_post.sv -----
// Gain compensation, rounding and saturation in four register stages.
module cpc_post #(
	parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  cpc_pkg::ctl_t                                 ctl_in,
	input  logic signed [cpc_pkg::COORD_W+DATA_WIDTH+2:0] x_in,
	input  logic signed [cpc_pkg::COORD_W+DATA_WIDTH+2:0] y_in,
	input  logic signed [cpc_pkg::Z_W-1:0]                z_in,
	output logic                                          vld,
	output cpc_pkg::res_t                                 res
);
	import cpc_pkg::*;

	localparam int XW = COORD_W + DATA_WIDTH + 3;
	// Quotient bits left after dropping 31 + DATA_WIDTH bits of the 96-bit product.
	localparam int QW = 65 - DATA_WIDTH;

	ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [31:0] z_s1, z_s2, z_s3;
	logic        neg_s1 [2];
	logic        neg_s2 [2];
	logic        neg_s3 [2];
	logic [XW-1:0] mag_s1 [2];
	logic [63:0] lo_s2 [2];
	logic [63:0] hi_s2 [2];
	logic [95:0] prod_s3 [2];
	res_t        res_s4;

	logic signed [XW-1:0] val [2];
	logic [63:0]          mag_ext [2];
	logic [QW-1:0]        quo [2];
	logic [QW-1:0]        rnd [2];
	logic [15:0]          sat [2];
	logic [15:0]          radius_d;
	logic [31:0]          z_rnd;
	res_t                 res_d;

	assign val[0] = x_in;
	assign val[1] = y_in;

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			mag_ext[c] = 64'(mag_s1[c]);
			quo[c]     = prod_s3[c][95:31+DATA_WIDTH];
			rnd[c]     = (quo[c] + QW'(1)) >> 1;
			// Signed saturation to the 16-bit range.
			if (neg_s3[c]) begin
				sat[c] = (rnd[c] > QW'(32768)) ? 16'h8000 : 16'(~rnd[c][15:0] + 16'd1);
			end else begin
				sat[c] = (rnd[c] > QW'(32767)) ? 16'h7FFF : rnd[c][15:0];
			end
		end

		if (neg_s3[0]) begin
			radius_d = '0;
		end else begin
			radius_d = (rnd[0] > QW'(65535)) ? 16'hFFFF : rnd[0][15:0];
		end
		z_rnd = z_s3 + 32'h00008000;

		res_d = '0;
		if (ctl_s3.op == OP_TO_POLAR) begin
			if (!ctl_s3.origin) begin
				res_d.radius_out = radius_d;
				res_d.angle_out  = z_rnd[31:16];
			end
		end else begin
			res_d.x_out = sat[0];
			res_d.y_out = sat[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= z_in[31:0];
			z_s2 <= z_s1;
			z_s3 <= z_s2;
			for (int c = 0; c < 2; c++) begin
				// Stage 1: magnitude and sign.
				neg_s1[c] <= val[c] < 0;
				mag_s1[c] <= (val[c] < 0) ? XW'(-val[c]) : XW'(val[c]);
				// Stage 2: two 32 by 32 partial products.
				neg_s2[c] <= neg_s1[c];
				lo_s2[c]  <= mag_ext[c][31:0] * GAIN_Q32;
				hi_s2[c]  <= mag_ext[c][63:32] * GAIN_Q32;
				// Stage 3: full product.
				neg_s3[c]  <= neg_s2[c];
				prod_s3[c] <= {hi_s2[c], 32'h0} + {32'h0, lo_s2[c]};
			end
			// Stage 4: rounding, saturation and field selection.
			res_s4 <= res_d;
		end
	end

	assign vld = ctl_s4.vld;
	assign res = res_s4;

endmodule

// ----- rtl/cpc_obuf.sv -----
// Two-entry output buffer that decouples the pipeline from the result consumer.
module cpc_obuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cpc_pkg::res_t din,
	output logic          full,
	output logic          m_tvalid,
	input  logic          m_tready,
	output cpc_pkg::res_t m_tdata
);
	import cpc_pkg::*;

	res_t head_q, tail_q;
	logic head_vld_q, tail_vld_q;
	logic pop;

	assign pop = head_vld_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			tail_vld_q <= 1'b0;
		end else if (pop) begin
			if (tail_vld_q) begin
				tail_vld_q <= 1'b0;
			end else begin
				head_vld_q <= push;
			end
		end else if (push) begin
			if (head_vld_q) begin
				tail_vld_q <= 1'b1;
			end else begin
				head_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (tail_vld_q) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= din;
			end
		end else if (push) begin
			if (head_vld_q) begin
				tail_q <= din;
			end else begin
				head_q <= din;
			end
		end
	end

	assign full     = tail_vld_q;
	assign m_tvalid = head_vld_q;
	assign m_tdata  = head_q;

endmodule

// ----- rtl/cartesian_polar_converter.sv -----
// Top level of the pipelined CORDIC Cartesian/polar coordinate converter.
//
//  Channel | Direction | Signals                              | Transaction
//  --------+-----------+--------------------------------------+--------------------------
//  s       | in        | s_tvalid s_tready s_tdata s_tuser    | one conversion request
//  m       | out       | m_tvalid m_tready m_tdata            | one conversion result
//
// One transaction enters every clock cycle while s_tready is high; items are independent.
// m_tvalid rises once a result has passed the input stage, which loads at the accepting
// edge, one stage per CORDIC micro-rotation, four gain and rounding stages and the
// output buffer.
// The two-entry output buffer sets s_tready: the pipeline freezes as a whole only while
// both entries hold results, and nothing in flight is lost or repeated.
// Reset is asynchronous and clears only valid and control bits; there is no clearing pass.
module cartesian_polar_converter #(
	parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEF,
	parameter int ITERATIONS = cpc_pkg::ITERATIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: x_in[15:0], y_in[31:16], radius_in[46:32], angle_in[62:47], zero.
	input  logic [63:0] s_tdata,
	// Fields from bit 0: opcode[0].
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: radius_out[15:0], angle_out[31:16], x_out[47:32], y_out[63:48].
	output logic [63:0] m_tdata
);
	import cpc_pkg::*;

	// Internal coordinate width: guard bits, input width and headroom for CORDIC growth.
	localparam int XW = COORD_W + DATA_WIDTH + 3;

	ctl_t                  ctl_c [ITERATIONS+1];
	logic signed [XW-1:0]  x_c   [ITERATIONS+1];
	logic signed [XW-1:0]  y_c   [ITERATIONS+1];
	logic signed [Z_W-1:0] z_c   [ITERATIONS+1];

	logic en;
	logic full;
	logic post_vld;
	res_t post_res;
	res_t out_res;

	// The whole pipeline advances unless the output buffer is full.
	assign en       = ~full;
	assign s_tready = en;

	cpc_pre #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld       (s_tvalid),
		.opcode    (op_t'(s_tuser)),
		.x_in      ($signed(s_tdata[15:0])),
		.y_in      ($signed(s_tdata[31:16])),
		.radius_in (s_tdata[46:32]),
		.angle_in  ($signed(s_tdata[62:47])),
		.ctl       (ctl_c[0]),
		.x         (x_c[0]),
		.y         (y_c[0]),
		.z         (z_c[0])
	);

	// One registered micro-rotation per iteration, shift equal to its index.
	for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
		cpc_iter #(
			.DATA_WIDTH(DATA_WIDTH),
			.SHIFT     (i)
		) u_iter (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_c[i]),
			.x_in    (x_c[i]),
			.y_in    (y_c[i]),
			.z_in    (z_c[i]),
			.ctl_out (ctl_c[i+1]),
			.x_out   (x_c[i+1]),
			.y_out   (y_c[i+1]),
			.z_out   (z_c[i+1])
		);
	end

	cpc_post #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (ctl_c[ITERATIONS]),
		.x_in   (x_c[ITERATIONS]),
		.y_in   (y_c[ITERATIONS]),
		.z_in   (z_c[ITERATIONS]),
		.vld    (post_vld),
		.res    (post_res)
	);

	// A finished result moves into the buffer on every cycle the pipeline advances.
	cpc_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (en & post_vld),
		.din      (post_res),
		.full     (full),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (out_res)
	);

	assign m_tdata = out_res;

endmodule

// ----- rtl/cpc_checker.sv -----
// Port-level assertions for the coordinate converter and their bind.
module cpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// A stalled result transaction holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// A result carries either polar or Cartesian fields, never both.
	a_one_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:0] == 32'h0) || (m_tdata[63:32] == 32'h0))
		else $error("result mixes polar and Cartesian fields");

	// Input backpressure only appears while results are waiting.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// Reset leaves the block empty with the input open on the first edge after release.
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid && s_tready)
		else $error("block not empty after reset");

endmodule

bind cartesian_polar_converter cpc_checker u_cpc_checker (.*);
